// File: hdl/mbra_pkg.sv
// Shared constants, types and helpers for the mix bus ring accumulator.
// No dependencies; used by the top level.
package mbra_pkg;

  localparam int SLOTS       = 16;
  localparam int RING_DEPTH  = 1024;
  localparam int SAMPLE_BITS = 24;

  // Port widths fixed by the item format
  localparam int FUNC_W   = 2;
  localparam int BUS_W    = 4;
  localparam int CHAN_W   = 4;
  localparam int POS_W    = 10;
  localparam int IO_BITS  = 24;
  localparam int CPB_W    = 5;
  localparam int RSL_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Derived sizes
  localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_CALC_W = CPB_W + BUS_W + 1;
  localparam int ADD_W   = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int MEM_DEPTH = (1 << SLOT_W) * RING_DEPTH;
  localparam int MEM_AW  = SLOT_W + IDX_W;
  localparam int SUM_W   = ((SAMPLE_BITS > IO_BITS) ? SAMPLE_BITS : IO_BITS) + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO =
    SUM_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [FUNC_W-1:0] {
    FN_READ    = 2'd0,
    FN_SUM     = 2'd1,
    FN_ZERO    = 2'd2,
    FN_ADVANCE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS_PER_BUS = 1'd0,
    CFG_RING_SIZE_LOG2   = 1'd1
  } cfg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] entry_t;

  // Saturating add of an input sample into a stored entry
  function automatic entry_t sat_add(entry_t a, logic signed [IO_BITS-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return SAMPLE_BITS'(s);
  endfunction

  // Entry to output width: sign extend or keep the low bits
  function automatic logic signed [IO_BITS-1:0] to_out(entry_t v);
    return IO_BITS'(v);
  endfunction

endpackage

// File: hdl/mbra_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbra_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mix_bus_ring_accumulator_unit.sv
// Mix bus ring accumulator: per-slot sample rings with a shared write index.
// Depends on mbra_pkg and mbra_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   in       | in_valid / in_stall       | func bus chan position offset sample_in
//            |                           | count last
//   out      | out_valid / out_stall     | sample_out last_out
//   cfg      | cfg_valid / cfg_ready     | cfg_index cfg_data
//
// One word enters per cycle when nothing downstream holds back. An accepted
// word issues its ring read at the accept edge; the modify stage then modifies
// the entry and writes it back (or loads the output register for a read), so
// the registered read of the ring RAM sets the two-stage depth. A write
// landing at the same edge as the next word's read is forwarded.
// Reset returns the write index and the config registers to their defaults
// and clears all valid flags; the ring RAM is not cleared, so there is no
// startup sweep.
// A read word whose result finds the output register full and stalled holds
// in the modify stage and stalls the input until out_stall drops.
module mix_bus_ring_accumulator_unit
  import mbra_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [FUNC_W-1:0]           func,
  input  logic [BUS_W-1:0]            bus,
  input  logic [CHAN_W-1:0]           chan,
  input  logic [POS_W-1:0]            position,
  input  logic [POS_W-1:0]            offset,
  input  logic signed [IO_BITS-1:0]   sample_in,
  input  logic [POS_W-1:0]            count,
  input  logic                        last,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [IO_BITS-1:0]   sample_out,
  output logic                        last_out,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // Config and index state
  logic [CPB_W-1:0] channels_per_bus;
  logic [RSL_W-1:0] ring_size_log2;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] mask;

  // Decode of the incoming word
  func_t                  in_func;
  logic                   accept;
  logic [SLOT_CALC_W-1:0] slot;
  logic                   slot_ok;
  logic [ADD_W-1:0]       base_sum;
  logic [IDX_W-1:0]       ring_addr;
  logic [MEM_AW-1:0]      rd_addr;

  // Modify stage
  logic                        p_valid;
  func_t                       p_func;
  logic                        p_ok;
  logic [MEM_AW-1:0]           p_addr;
  logic signed [IO_BITS-1:0]   p_sample;
  logic                        p_last;
  logic                        p_done;

  // Ring RAM and forwarding
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [MEM_AW-1:0]      wr_addr;
  entry_t                 wr_data;
  logic                   fwd_hit;
  entry_t                 fwd_data;
  entry_t                 old_entry;

  assign cfg_ready = 1'b1;

  // Mask: bit i set while i is below ring_size_log2, capped by the ring depth
  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (int'(ring_size_log2) > i);
    end
  end

  assign in_func = func_t'(func);
  assign accept  = in_valid && !in_stall;

  assign slot    = SLOT_CALC_W'(channels_per_bus) * SLOT_CALC_W'(bus) + SLOT_CALC_W'(chan);
  assign slot_ok = (slot < SLOT_CALC_W'(SLOTS));

  // Read words look behind the write index by offset; sum and zero do not
  always_comb begin
    if (in_func == FN_READ) begin
      base_sum = ADD_W'(write_index) - ADD_W'(offset) + ADD_W'(position);
    end else begin
      base_sum = ADD_W'(write_index) + ADD_W'(position);
    end
    ring_addr = IDX_W'(base_sum) & mask;
    rd_addr   = {slot[SLOT_W-1:0], ring_addr};
  end

  // A read word holds here while the output register cannot take its result
  assign p_done   = p_valid && !(p_func == FN_READ && out_valid && out_stall);
  assign in_stall = p_valid && !p_done;

  assign old_entry = fwd_hit ? fwd_data : entry_t'(rd_data);
  assign wr_en     = p_done && p_ok && (p_func == FN_SUM || p_func == FN_ZERO);
  assign wr_addr   = p_addr;
  assign wr_data   = (p_func == FN_ZERO) ? '0 : sat_add(old_entry, p_sample);

  mbra_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Config registers and the shared write index
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_per_bus <= CPB_W'(2);
      ring_size_log2   <= RSL_W'(10);
      write_index      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CHANNELS_PER_BUS: channels_per_bus <= CPB_W'(cfg_data);
          CFG_RING_SIZE_LOG2:   ring_size_log2   <= RSL_W'(cfg_data);
        endcase
      end
      // Advance at accept so the next word already sees the new index
      if (accept && in_func == FN_ADVANCE) begin
        write_index <= IDX_W'(ADD_W'(write_index) + ADD_W'(count)) & mask;
      end
    end
  end

  // Modify stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_done) begin
      p_valid <= 1'b0;
    end
  end

  // Modify stage payload; capture forwarding when the write hits the new read
  always_ff @(posedge clk) begin
    if (accept) begin
      p_func   <= in_func;
      p_ok     <= slot_ok;
      p_addr   <= rd_addr;
      p_sample <= sample_in;
      p_last   <= last;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_done && p_func == FN_READ) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_done && p_func == FN_READ) begin
      sample_out <= p_ok ? to_out(old_entry) : '0;
      last_out   <= p_last;
    end
  end

endmodule

// File: tb/sv/mix_bus_ring_accumulator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for mix_bus_ring_accumulator_unit: a ring mirror predicts
// every readback word. Depends on mbra_pkg and the RTL of the unit only.
module mix_bus_ring_accumulator_unit_test;
  import mbra_pkg::*;

  localparam int SMP_MAX       = 8388607;
  localparam int SMP_MIN       = -8388608;
  localparam int SETTLE_CYCLES = 6;     // two-stage pipe plus margin
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 135;

  // One input word as the bench sees it
  typedef struct {
    func_t                     fn;
    logic [BUS_W-1:0]          bus;
    logic [CHAN_W-1:0]         chan;
    logic [POS_W-1:0]          pos;
    logic [POS_W-1:0]          off;
    logic signed [IO_BITS-1:0] smp;
    logic [POS_W-1:0]          cnt;
    logic                      lst;
  } word_t;

  // One readback word
  typedef struct {
    logic signed [IO_BITS-1:0] smp;
    logic                      lst;
  } readback_t;

  // Mirror of the sample rings, the shared write index and the two registers.
  // It also keeps which entries were zeroed, so that stimulus never reads or
  // sums into an entry whose contents are still undefined.
  class ring_mirror;
    entry_t           store [SLOTS][RING_DEPTH];
    bit               zeroed [SLOTS][RING_DEPTH];
    logic [IDX_W-1:0] wr_idx;
    logic [CPB_W-1:0] chans_per_bus;
    logic [RSL_W-1:0] size_log2;
    readback_t        readbacks_due[$];
    int               faults;

    function new();
      zeroed        = '{default: 1'b0};
      wr_idx        = '0;
      chans_per_bus = CPB_W'(2);
      size_log2     = RSL_W'(10);
      faults        = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CHANNELS_PER_BUS) begin
        chans_per_bus = data;
      end else begin
        size_log2 = data[RSL_W-1:0];
      end
    endfunction

    // Ring length in use is capped by the physical depth
    function logic [IDX_W-1:0] mask();
      int m;
      m = (1 << size_log2) - 1;
      return IDX_W'(m & (RING_DEPTH - 1));
    endfunction

    function int slot_of(logic [BUS_W-1:0] b, logic [CHAN_W-1:0] c);
      return int'(chans_per_bus) * int'(b) + int'(c);
    endfunction

    function logic [IDX_W-1:0] read_addr(word_t w);
      return IDX_W'((int'(wr_idx) - int'(w.off) + int'(w.pos)) & int'(mask()));
    endfunction

    function logic [IDX_W-1:0] sum_addr(word_t w);
      return IDX_W'((int'(wr_idx) + int'(w.pos)) & int'(mask()));
    endfunction

    // A read or sum is safe when it hits no slot or a zeroed entry
    function bit read_ok(word_t w);
      int slot;
      slot = slot_of(w.bus, w.chan);
      if (slot >= SLOTS) begin
        return 1'b1;
      end
      if (w.fn == FN_READ) begin
        return zeroed[slot][read_addr(w)];
      end
      if (w.fn == FN_SUM) begin
        return zeroed[slot][sum_addr(w)];
      end
      return 1'b1;
    endfunction

    function int pending();
      return readbacks_due.size();
    endfunction

    // Advance the mirror by one accepted word
    function void take_word(word_t w);
      int               slot;
      int               acc;
      logic [IDX_W-1:0] msk;
      logic [IDX_W-1:0] at;
      readback_t        r;
      msk  = mask();
      slot = slot_of(w.bus, w.chan);
      case (w.fn)
        FN_ADVANCE: begin
          wr_idx = IDX_W'(int'(wr_idx) + int'(w.cnt)) & msk;
        end
        FN_READ: begin
          r.smp = '0;
          if (slot < SLOTS) begin
            r.smp = store[slot][read_addr(w)];
          end
          r.lst = w.lst;
          readbacks_due.push_back(r);
        end
        default: begin
          if (slot < SLOTS) begin
            at = IDX_W'((int'(wr_idx) + int'(w.pos)) & int'(msk));
            if (w.fn == FN_ZERO) begin
              store[slot][at]  = '0;
              zeroed[slot][at] = 1'b1;
            end else begin
              // Sums only land on zeroed entries, which stay defined
              acc = int'(store[slot][at]) + int'(w.smp);
              if (acc > SMP_MAX) acc = SMP_MAX;
              if (acc < SMP_MIN) acc = SMP_MIN;
              store[slot][at] = entry_t'(acc);
            end
          end
        end
      endcase
    endfunction

    function void compare_readback(logic signed [IO_BITS-1:0] got_smp, logic got_lst);
      readback_t e;
      if (readbacks_due.size() == 0) begin
        $error("readback word with none due: sample_out %0d last_out %0b", got_smp, got_lst);
        faults++;
        return;
      end
      e = readbacks_due.pop_front();
      if (got_smp !== e.smp) begin
        $error("sample_out: expected %0d, actual %0d", e.smp, got_smp);
        faults++;
      end
      if (got_lst !== e.lst) begin
        $error("last_out: expected %0b, actual %0b", e.lst, got_lst);
        faults++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func      = '0;
  logic [BUS_W-1:0]          bus       = '0;
  logic [CHAN_W-1:0]         chan      = '0;
  logic [POS_W-1:0]          position  = '0;
  logic [POS_W-1:0]          offset    = '0;
  logic signed [IO_BITS-1:0] sample_in = '0;
  logic [POS_W-1:0]          count     = '0;
  logic                      last      = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [IO_BITS-1:0] sample_out;
  logic                      last_out;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;

  ring_mirror ring = new();
  int         in_idle_pct   = 0;
  int         out_stall_pct = 0;
  int         words_sent    = 0;
  int         quiet_cycles  = 0;

  mix_bus_ring_accumulator_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .bus        (bus),
    .chan       (chan),
    .position   (position),
    .offset     (offset),
    .sample_in  (sample_in),
    .count      (count),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last_out   (last_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the readback side at random, once per cycle
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < out_stall_pct);
  end

  // Check every readback word taken at this edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ring.compare_readback(sample_out, last_out);
    end
  end

  // Watchdog: drop the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fully random word; every bit of every field can toggle
  function automatic word_t rand_word();
    word_t w;
    w.fn   = func_t'($urandom_range(3));
    w.bus  = BUS_W'($urandom);
    w.chan = CHAN_W'($urandom);
    w.pos  = POS_W'($urandom);
    w.off  = POS_W'($urandom);
    w.smp  = IO_BITS'($urandom);
    w.cnt  = POS_W'($urandom);
    w.lst  = 1'($urandom);
    return w;
  endfunction

  function automatic word_t mk(func_t fn, int b, int c, int p, int o, int s, int n, bit l);
    word_t w;
    w.fn   = fn;
    w.bus  = BUS_W'(b);
    w.chan = CHAN_W'(c);
    w.pos  = POS_W'(p);
    w.off  = POS_W'(o);
    w.smp  = IO_BITS'(s);
    w.cnt  = POS_W'(n);
    w.lst  = l;
    return w;
  endfunction

  // Steer reads and sums away from undefined entries: retry the position, and
  // failing that turn the word into a zero of the very entry it would touch
  function automatic word_t legal_read(word_t w);
    for (int i = 0; i < 8 && !ring.read_ok(w); i++) begin
      w.pos = POS_W'($urandom);
    end
    if (!ring.read_ok(w)) begin
      if (w.fn == FN_READ) begin
        w.pos = w.pos - w.off;
      end
      w.fn = FN_ZERO;
    end
    return w;
  endfunction

  // Hold the word until it is taken, then advance the mirror
  task automatic send_word(word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= w.fn;
    bus       <= w.bus;
    chan      <= w.chan;
    position  <= w.pos;
    offset    <= w.off;
    sample_in <= w.smp;
    count     <= w.cnt;
    last      <= w.lst;
    do @(posedge clk); while (in_stall);
    ring.take_word(w);
    words_sent++;
  endtask

  // Drop valid, wait for every readback due, then let the pipe settle
  task automatic pause_for_results();
    in_valid <= 1'b0;
    while (ring.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two
  task automatic set_config(int cpb, int rsl);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHANNELS_PER_BUS;
    cfg_data  <= CFG_DATA_W'(cpb);
    do @(posedge clk); while (!cfg_ready);
    ring.set_reg(CFG_CHANNELS_PER_BUS, CFG_DATA_W'(cpb));
    cfg_index <= CFG_RING_SIZE_LOG2;
    cfg_data  <= CFG_DATA_W'(rsl);
    do @(posedge clk); while (!cfg_ready);
    ring.set_reg(CFG_RING_SIZE_LOG2, CFG_DATA_W'(rsl));
    cfg_valid <= 1'b0;
  endtask

  // One mixing block as an engine streams it: zero the span, sum into it one
  // to three times, read it back, maybe read an older spot, then advance.
  task automatic run_block();
    int                top;
    int                span;
    int                passes;
    logic [BUS_W-1:0]  b;
    logic [CHAN_W-1:0] c;
    word_t             w;
    top  = int'(ring.mask()) + 1;
    span = $urandom_range(1, ($urandom_range(7) == 0) ? 32 : 8);
    if (span > top) span = top;
    b = BUS_W'($urandom);
    c = CHAN_W'($urandom);
    // Aim mostly at slots that exist; wide buses leave only bus 0 in range
    for (int i = 0; i < 6 && ring.slot_of(b, c) >= SLOTS; i++) begin
      b = ($urandom_range(1) != 0) ? '0 : BUS_W'($urandom);
      c = CHAN_W'($urandom);
    end
    passes = $urandom_range(1, 3);
    for (int i = 0; i < span; i++) begin
      w = rand_word();
      w.fn = FN_ZERO; w.bus = b; w.chan = c; w.pos = POS_W'(i); w.lst = (i == span - 1);
      send_word(w);
    end
    for (int p = 0; p < passes; p++) begin
      for (int i = 0; i < span; i++) begin
        w = rand_word();
        w.fn = FN_SUM; w.bus = b; w.chan = c; w.pos = POS_W'(i); w.lst = (i == span - 1);
        // Push some sums hard against the rails
        if ($urandom_range(7) == 0) begin
          w.smp = ($urandom_range(1) != 0) ? IO_BITS'(SMP_MAX) : IO_BITS'(SMP_MIN);
        end
        send_word(w);
      end
    end
    for (int i = 0; i < span; i++) begin
      w = rand_word();
      w.fn = FN_READ; w.bus = b; w.chan = c; w.pos = POS_W'(i); w.off = '0;
      w.lst = (i == span - 1);
      send_word(legal_read(w));
    end
    if ($urandom_range(2) == 0) begin
      w = rand_word();
      w.fn = FN_READ; w.bus = b; w.chan = c; w.pos = POS_W'($urandom_range(span - 1));
      w.off = POS_W'($urandom_range(top - 1));
      send_word(legal_read(w));
    end
    w = rand_word();
    w.fn = FN_ADVANCE;
    if ($urandom_range(7) != 0) w.cnt = POS_W'(span);
    send_word(w);
  endtask

  initial begin
    int stop_at;
    int phase_idle  [PHASES] = '{0, 71, 0, 26, 0, 71, 0, 26};
    int phase_stall [PHASES] = '{0, 0, 71, 26, 0, 0, 71, 26};
    int phase_cpb   [PHASES] = '{1, 16, 0, 31, 2, 4, 3, 8};
    int phase_rsl   [PHASES] = '{10, 1, 0, 15, 3, 10, 5, 7};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: two channels per bus, full ring,
    // write index at zero. Slot 0 is bus 0 chan 0, slot 15 is bus 7 chan 1.
    send_word(mk(FN_ZERO,    0,  0,    0,    0, 0,        0,    0));
    send_word(mk(FN_SUM,     0,  0,    0,    0, SMP_MAX,  0,    0));
    send_word(mk(FN_SUM,     0,  0,    0,    0, SMP_MAX,  0,    1)); // clip high
    send_word(mk(FN_READ,    0,  0,    0,    0, 0,        0,    1));
    send_word(mk(FN_SUM,     0,  0,    0,    0, SMP_MIN,  0,    0));
    send_word(mk(FN_SUM,     0,  0,    0,    0, SMP_MIN,  0,    0)); // clip low
    send_word(mk(FN_READ,    0,  0,    0,    0, 0,        0,    0));
    // Slot beyond the store: writes dropped, read gives zero
    send_word(mk(FN_ZERO,    15, 15,   5,    0, 0,        0,    0));
    send_word(mk(FN_SUM,     15, 15,   5,    0, SMP_MAX,  0,    0));
    send_word(mk(FN_READ,    15, 15,   1023, 1023, 0,     0,    1));
    send_word(mk(FN_ZERO,    7,  1,    1023, 0, 0,        0,    0));
    send_word(mk(FN_SUM,     7,  1,    1023, 0, 'h5A5A5A, 0,    1));
    send_word(mk(FN_READ,    7,  1,    1023, 0, 0,        0,    0));
    send_word(mk(FN_ADVANCE, 0,  0,    0,    0, 0,        1023, 0));
    // Index now 1023: a full offset reaches back to entry 0
    send_word(mk(FN_READ,    0,  0,    0,    1023, 0,     0,    0));
    send_word(mk(FN_READ,    7,  1,    0,    0, 0,        0,    1));
    send_word(mk(FN_SUM,     7,  1,    0,    0, -5921371, 0,    0));
    send_word(mk(FN_READ,    7,  1,    0,    0, 0,        0,    1));
    // Index wraps back to zero; a zero count leaves it put
    send_word(mk(FN_ADVANCE, 0,  0,    0,    0, 0,        1,    0));
    send_word(mk(FN_ADVANCE, 0,  0,    0,    0, 0,        0,    1));
    send_word(mk(FN_READ,    0,  0,    0,    0, 0,        0,    1));

    // Random phases, each with its own register setting and idle profile.
    // Covered settings: zero channels per bus, widest bus, ring of one entry,
    // size above the physical depth.
    for (int ph = 0; ph < PHASES; ph++) begin
      pause_for_results();
      set_config(phase_cpb[ph], phase_rsl[ph]);
      in_idle_pct   = phase_idle[ph];
      out_stall_pct = phase_stall[ph];
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
        if ($urandom_range(4) != 0) begin
          run_block();
        end else begin
          repeat ($urandom_range(1, 4)) send_word(legal_read(rand_word()));
        end
        // Now and then hold the sender until every readback is in
        if ($urandom_range(30) == 0) begin
          pause_for_results();
        end
      end
    end

    pause_for_results();
    if (ring.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
